/* rtl/tslf_pkg.sv */
// Package for the text stream line formatter.
// Holds character codes, sizes of the output run, and the shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tslf_pkg;

  // Digits in the line number prefix.
  localparam int NUMBER_DIGITS = 6;
  // Run storage: room for the number prefix and tab plus a four-byte tail.
  // A numbered run carries at most two tail bytes, so no run exceeds nine bytes.
  localparam int TAIL_MAX  = 4;
  localparam int RUN_MAX   = NUMBER_DIGITS + 1 + TAIL_MAX;
  localparam int RUN_CNT_W = $clog2(RUN_MAX + 1);
  localparam int CFG_INDEX_W = 3;

  typedef logic [7:0] byte_t;

  localparam byte_t CHAR_TAB    = 8'd9;
  localparam byte_t CHAR_LF     = 8'd10;
  localparam byte_t CHAR_CR     = 8'd13;
  localparam byte_t CHAR_SPACE  = 8'd32;
  localparam byte_t CHAR_DOLLAR = 8'h24;
  localparam byte_t CHAR_ZERO   = 8'h30;
  localparam byte_t CHAR_QMARK  = 8'h3F;
  localparam byte_t CHAR_I      = 8'h49;
  localparam byte_t CHAR_M      = 8'h4D;
  localparam byte_t CHAR_CARET  = 8'h5E;
  localparam byte_t CHAR_DEL    = 8'd127;
  localparam byte_t CARET_OFFSET = 8'd64;

  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_EOF  = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NUMBER_ALL       = 3'd0,
    REG_NUMBER_NONBLANK  = 3'd1,
    REG_SQUEEZE_BLANK    = 3'd2,
    REG_SHOW_LINE_ENDS   = 3'd3,
    REG_SHOW_TABS        = 3'd4,
    REG_SHOW_NONPRINTING = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic number_all_lines;
    logic number_nonblank_lines;
    logic squeeze_blank_lines;
    logic show_line_ends;
    logic show_tabs;
    logic show_nonprinting;
  } cfg_t;

  // Line number kept as BCD digits, digit 0 least significant.
  typedef logic [NUMBER_DIGITS-1:0][3:0] bcd_t;

  typedef logic [RUN_MAX-1:0][7:0] run_data_t;

  typedef struct packed {
    run_data_t            data;
    logic [RUN_CNT_W-1:0] len;
  } run_t;

endpackage

`default_nettype wire

/* rtl/text_stream_line_formatter_top.sv */
// Top level of the text stream line formatter.
// Holds the configuration registers; uses tslf_format, tslf_run_buf and tslf_pkg.
//
// Usage: the input channel (in_valid, in_stall, req_type, data_byte) carries
// one data byte or an end-of-file flush per transaction. Each one produces a
// run of zero to nine bytes on the output channel (out_valid, out_stall,
// out_byte, run_last), run_last marking the final byte of the run.
// The run is built in the cycle the input transaction is taken and stored in
// the run register; its first byte appears on the next cycle. The run
// register sends one byte per cycle while the receiver does not stall: plain
// bytes stream at one per cycle, while a numbered line start (six digits, a tab
// and up to two more bytes) holds the input until its whole run has been
// taken. A new item is taken in the same cycle the last byte of the previous
// run is taken.
// Items that give an empty run (a held carriage return, a squeezed blank
// line) are absorbed without output.
// When the receiver stalls, the current byte holds; in_stall stays high while
// any byte of a run is waiting and drops only in the cycle its last byte is
// taken. Reset clears the options, sets the line number to one and treats the
// stream as being at the start of a line.
// Configuration is written through cfg_write, cfg_index and cfg_data while idle.
`timescale 1ns / 1ps
`default_nettype none

module text_stream_line_formatter_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [tslf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic                             cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             req_type,
  input  logic [7:0]                       data_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_byte,
  output logic                             run_last
);
  import tslf_pkg::*;

  cfg_t cfg;
  run_t run;
  logic load;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_NUMBER_ALL:       cfg.number_all_lines      <= cfg_data;
        REG_NUMBER_NONBLANK:  cfg.number_nonblank_lines <= cfg_data;
        REG_SQUEEZE_BLANK:    cfg.squeeze_blank_lines   <= cfg_data;
        REG_SHOW_LINE_ENDS:   cfg.show_line_ends        <= cfg_data;
        REG_SHOW_TABS:        cfg.show_tabs             <= cfg_data;
        REG_SHOW_NONPRINTING: cfg.show_nonprinting      <= cfg_data;
        default: ;
      endcase
    end
  end

  tslf_format u_format (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .take      (load),
    .req_type  (req_type),
    .data_byte (data_byte),
    .run       (run)
  );

  tslf_run_buf u_run_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .run       (run),
    .load      (load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .run_last  (run_last)
  );

endmodule

`default_nettype wire

/* rtl/tslf_format.sv */
// Formatter state and run builder for the text stream line formatter.
// Builds the whole output run of one transaction and updates state on take.
// Depends on tslf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tslf_format (
  input  logic          clk,
  input  logic          rst,
  input  tslf_pkg::cfg_t cfg,
  input  logic          take,
  input  logic          req_type,
  input  logic [7:0]    data_byte,
  output tslf_pkg::run_t run
);
  import tslf_pkg::*;

  byte_t prev_byte;
  byte_t prev_byte_next;
  bcd_t  line_bcd;
  bcd_t  line_bcd_next;
  logic [1:0] blank_run;
  logic [1:0] blank_run_next;

  logic held;
  logic is_lf;
  logic prev_lf;
  logic number_fire;
  logic [1:0][7:0] hp;
  logic [1:0] hp_len;
  logic [1:0][7:0] bp;
  logic [1:0] bp_len;
  logic [TAIL_MAX-1:0][7:0] tail;
  logic [2:0] tail_len;
  logic [NUMBER_DIGITS:0][7:0] prefix;
  logic lead;
  logic all_nine;
  logic carry;
  logic [3:0] dg;

  // Saturating BCD increment of the line number.
  always_comb begin
    all_nine = 1'b1;
    carry = 1'b1;
    line_bcd_next = line_bcd;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (line_bcd[i] != 4'd9) all_nine = 1'b0;
      if (carry) begin
        if (line_bcd[i] == 4'd9) begin
          line_bcd_next[i] = 4'd0;
        end else begin
          line_bcd_next[i] = line_bcd[i] + 4'd1;
          carry = 1'b0;
        end
      end
    end
    if (all_nine) line_bcd_next = line_bcd;
  end

  // Number prefix: right-justified digits with leading spaces, then tab.
  always_comb begin
    lead = 1'b1;
    dg = 4'd0;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      dg = line_bcd[NUMBER_DIGITS-1-i];
      if (lead && dg == 4'd0 && i != NUMBER_DIGITS - 1) begin
        prefix[i] = CHAR_SPACE;
      end else begin
        lead = 1'b0;
        prefix[i] = CHAR_ZERO + {4'd0, dg};
      end
    end
    prefix[NUMBER_DIGITS] = CHAR_TAB;
  end

  always_comb begin
    held    = (prev_byte == CHAR_CR);
    is_lf   = (data_byte == CHAR_LF);
    prev_lf = (prev_byte == CHAR_LF);
    prev_byte_next = prev_byte;
    blank_run_next = blank_run;
    number_fire = 1'b0;
    hp = '0;
    hp_len = 2'd0;
    bp = '0;
    bp_len = 2'd0;

    if (req_type == REQ_EOF) begin
      if (held) begin
        hp[0] = CHAR_CR;
        hp_len = 2'd1;
        prev_byte_next = 8'd0;
      end
    end else begin
      blank_run_next = 2'd0;
      if (cfg.squeeze_blank_lines && is_lf && prev_lf) begin
        blank_run_next = (blank_run == 2'd3) ? 2'd3 : blank_run + 2'd1;
      end

      // With squeezing on, a second or later blank line in a row vanishes entirely.
      if (!blank_run_next[1]) begin
        if (cfg.number_nonblank_lines) number_fire = prev_lf && !is_lf;
        else number_fire = cfg.number_all_lines && prev_lf;

        if (is_lf) begin
          if (held) begin
            if (cfg.show_line_ends) begin
              hp[0] = CHAR_CARET;
              hp[1] = CHAR_M;
              hp_len = 2'd2;
            end else begin
              hp[0] = CHAR_CR;
              hp_len = 2'd1;
            end
          end
          if (cfg.show_line_ends) begin
            bp[0] = CHAR_DOLLAR;
            bp[1] = CHAR_LF;
            bp_len = 2'd2;
          end else begin
            bp[0] = CHAR_LF;
            bp_len = 2'd1;
          end
          prev_byte_next = CHAR_LF;
        end else begin
          if (held) begin
            hp[0] = CHAR_CR;
            hp_len = 2'd1;
          end
          if (data_byte == CHAR_CR && cfg.show_line_ends && !cfg.show_nonprinting) begin
            // Hold the carriage return until the next byte is seen.
            prev_byte_next = CHAR_CR;
          end else begin
            if (cfg.show_nonprinting && data_byte == CHAR_DEL) begin
              bp[0] = CHAR_CARET;
              bp[1] = CHAR_QMARK;
              bp_len = 2'd2;
            end else if (cfg.show_nonprinting && data_byte < CHAR_SPACE
                         && data_byte != CHAR_TAB) begin
              bp[0] = CHAR_CARET;
              bp[1] = data_byte + CARET_OFFSET;
              bp_len = 2'd2;
            end else if (cfg.show_tabs && data_byte == CHAR_TAB) begin
              bp[0] = CHAR_CARET;
              bp[1] = CHAR_I;
              bp_len = 2'd2;
            end else begin
              bp[0] = data_byte;
              bp_len = 2'd1;
            end
            prev_byte_next = (data_byte == CHAR_CR) ? 8'd0 : data_byte;
          end
        end
      end
    end
  end

  // Tail of the run: held part followed by the body.
  always_comb begin
    tail = '0;
    case (hp_len)
      2'd0: begin
        tail[0] = bp[0];
        tail[1] = bp[1];
      end
      2'd1: begin
        tail[0] = hp[0];
        tail[1] = bp[0];
        tail[2] = bp[1];
      end
      default: begin
        tail[0] = hp[0];
        tail[1] = hp[1];
        tail[2] = bp[0];
        tail[3] = bp[1];
      end
    endcase
    tail_len = {1'b0, hp_len} + {1'b0, bp_len};
  end

  always_comb begin
    run.data = '0;
    if (number_fire) begin
      for (int i = 0; i <= NUMBER_DIGITS; i++) run.data[i] = prefix[i];
      for (int k = 0; k < TAIL_MAX; k++) run.data[NUMBER_DIGITS+1+k] = tail[k];
      run.len = RUN_CNT_W'(NUMBER_DIGITS + 1) + RUN_CNT_W'(tail_len);
    end else begin
      for (int k = 0; k < TAIL_MAX; k++) run.data[k] = tail[k];
      run.len = RUN_CNT_W'(tail_len);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_byte <= CHAR_LF;
      line_bcd  <= bcd_t'(1);
      blank_run <= 2'd0;
    end else if (take) begin
      prev_byte <= prev_byte_next;
      blank_run <= blank_run_next;
      if (number_fire) line_bcd <= line_bcd_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/tslf_run_buf.sv */
// Output run register of the text stream line formatter.
// Loads a whole run and shifts it out one byte per transaction.
// Depends on tslf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tslf_run_buf (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  tslf_pkg::run_t run,
  output logic           load,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           run_last
);
  import tslf_pkg::*;

  run_data_t            run_data;
  logic [RUN_CNT_W-1:0] cnt;
  logic                 pop;
  logic                 free;

  assign out_valid = (cnt != '0);
  assign out_byte  = run_data[0];
  assign run_last  = (cnt == RUN_CNT_W'(1));
  assign pop       = out_valid && !out_stall;
  // A new run may enter in the same cycle the last byte of the old one leaves.
  assign free      = !out_valid || (run_last && pop);
  assign in_stall  = !free;
  assign load      = in_valid && free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= run.len;
    end else if (pop) begin
      cnt <= cnt - RUN_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      run_data <= run.data;
    end else if (pop) begin
      run_data <= {8'h00, run_data[RUN_MAX-1:1]};
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> (cnt == '0 || (cnt == RUN_CNT_W'(1) && pop)))
    else $error("run loaded over bytes not yet sent");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= RUN_CNT_W'(RUN_MAX))
    else $error("run count out of range");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (pop && !load) |=> cnt == $past(cnt) - RUN_CNT_W'(1))
    else $error("run count did not step down on a sent byte");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    (load && run.len != '0) |=> (out_valid && out_byte == $past(run.data[0])))
    else $error("loaded run not presented");

endmodule

`default_nettype wire

/* tb/text_stream_line_formatter_top_tb.sv */
// Self-checking testbench for text_stream_line_formatter_top.
// Predicts the formatted byte run of every input transaction and compares it
// with the output channel; depends on tslf_pkg and the formatter RTL.
`timescale 1ns / 1ps

module text_stream_line_formatter_top_tb;
  import tslf_pkg::*;

  localparam int LINE_NUM_MAX = 10 ** NUMBER_DIGITS - 1;
  localparam int DRAIN_CYCLES = 6;
  localparam int LONG_HOLD_CYCLES = 150;
  localparam longint TIMEOUT_NS = 64'd30_000_000;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    byte_t data;
    logic  last;
  } run_byte_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_NUMBER_ALL;
  logic                   cfg_data = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   req_type = REQ_DATA;
  logic [7:0]             data_byte = 8'd0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [7:0]             out_byte;
  logic                   run_last;

  // Predictor state.
  cfg_t  opt;
  byte_t last_emitted;
  int    line_num;
  int    blank_cnt;
  byte_t run_bytes[$];
  run_byte_t expected_run[$];
  run_byte_t head_byte;

  int  fail_count = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  logic holding_off = 1'b0;
  event long_hold_ev;

  text_stream_line_formatter_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .run_last  (run_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("text_stream_line_formatter_top: mismatch");
    $finish;
  end

  // Works out the byte run of one transaction and queues it.
  task automatic predict_run(logic rtype, byte_t c);
    logic  held;
    logic  do_num;
    logic  lead;
    int    v;
    byte_t digit_val[NUMBER_DIGITS];
    held = (last_emitted == CHAR_CR);
    run_bytes.delete();
    if (rtype == REQ_EOF) begin
      if (held) begin
        run_bytes.push_back(CHAR_CR);
        last_emitted = 8'd0;
      end
    end else begin
      if (opt.squeeze_blank_lines && c == CHAR_LF && last_emitted == CHAR_LF) begin
        if (blank_cnt < 3) blank_cnt++;
      end else begin
        blank_cnt = 0;
      end
      // With squeezing on, a second or later blank line in a row vanishes entirely.
      if (blank_cnt < 2) begin
        if (opt.number_nonblank_lines) begin
          do_num = (last_emitted == CHAR_LF) && (c != CHAR_LF);
        end else begin
          do_num = opt.number_all_lines && (last_emitted == CHAR_LF);
        end
        if (do_num) begin
          v = line_num;
          for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
            digit_val[i] = byte_t'(v % 10);
            v = v / 10;
          end
          lead = 1'b1;
          for (int i = 0; i < NUMBER_DIGITS; i++) begin
            if (lead && digit_val[i] == 0 && i != NUMBER_DIGITS - 1) begin
              run_bytes.push_back(CHAR_SPACE);
            end else begin
              lead = 1'b0;
              run_bytes.push_back(CHAR_ZERO + digit_val[i]);
            end
          end
          run_bytes.push_back(CHAR_TAB);
          if (line_num < LINE_NUM_MAX) line_num++;
        end
        if (c == CHAR_LF) begin
          if (held) begin
            if (opt.show_line_ends) begin
              run_bytes.push_back(CHAR_CARET);
              run_bytes.push_back(CHAR_M);
            end else begin
              run_bytes.push_back(CHAR_CR);
            end
          end
          if (opt.show_line_ends) run_bytes.push_back(CHAR_DOLLAR);
          run_bytes.push_back(CHAR_LF);
          last_emitted = CHAR_LF;
        end else begin
          if (held) run_bytes.push_back(CHAR_CR);
          if (c == CHAR_CR && opt.show_line_ends && !opt.show_nonprinting) begin
            last_emitted = CHAR_CR;
          end else begin
            if (opt.show_nonprinting && c == CHAR_DEL) begin
              run_bytes.push_back(CHAR_CARET);
              run_bytes.push_back(CHAR_QMARK);
            end else if (opt.show_nonprinting && c < CHAR_SPACE && c != CHAR_TAB) begin
              run_bytes.push_back(CHAR_CARET);
              run_bytes.push_back(c + CARET_OFFSET);
            end else if (opt.show_tabs && c == CHAR_TAB) begin
              run_bytes.push_back(CHAR_CARET);
              run_bytes.push_back(CHAR_I);
            end else begin
              run_bytes.push_back(c);
            end
            last_emitted = (c == CHAR_CR) ? 8'd0 : c;
          end
        end
      end
    end
    for (int i = 0; i < run_bytes.size(); i++) begin
      expected_run.push_back('{data: run_bytes[i], last: (i == run_bytes.size() - 1)});
    end
  endtask

  // Input monitor: every accepted transaction feeds the predictor.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) predict_run(req_type, data_byte);
  end

  // Output checker.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_run.size() == 0) begin
        $display("%0t: unexpected byte, expected none, actual out_byte %h run_last %b",
                 $time, out_byte, run_last);
        fail_count++;
      end else begin
        head_byte = expected_run.pop_front();
        if (out_byte !== head_byte.data) begin
          $display("%0t: out_byte expected %h actual %h", $time, head_byte.data, out_byte);
          fail_count++;
        end
        if (run_last !== head_byte.last) begin
          $display("%0t: run_last expected %b actual %b", $time, head_byte.last, run_last);
          fail_count++;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold on request.
  always @(posedge clk) begin
    out_stall <= holding_off || ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    forever begin
      @(long_hold_ev);
      holding_off <= 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clk);
      holding_off <= 1'b0;
    end
  end

  task automatic send_item(logic rtype, byte_t b);
    in_valid  <= 1'b1;
    req_type  <= rtype;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_run.size() != 0) @(posedge clk);
    // An absorbed transaction may still be in flight with nothing queued.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_NUMBER_ALL:       opt.number_all_lines      = val;
      REG_NUMBER_NONBLANK:  opt.number_nonblank_lines = val;
      REG_SQUEEZE_BLANK:    opt.squeeze_blank_lines   = val;
      REG_SHOW_LINE_ENDS:   opt.show_line_ends        = val;
      REG_SHOW_TABS:        opt.show_tabs             = val;
      REG_SHOW_NONPRINTING: opt.show_nonprinting      = val;
      default: ;
    endcase
  endtask

  task automatic set_options(cfg_t c);
    wait_drained();
    write_reg(REG_NUMBER_ALL, c.number_all_lines);
    write_reg(REG_NUMBER_NONBLANK, c.number_nonblank_lines);
    write_reg(REG_SQUEEZE_BLANK, c.squeeze_blank_lines);
    write_reg(REG_SHOW_LINE_ENDS, c.show_line_ends);
    write_reg(REG_SHOW_TABS, c.show_tabs);
    write_reg(REG_SHOW_NONPRINTING, c.show_nonprinting);
    // Writes to unused indexes must leave every option alone.
    write_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 1'($urandom_range(1)));
    cfg_write <= 1'b0;
  endtask

  task automatic test_plain_bytes();
    set_options(cfg_t'(0));
    send_item(REQ_DATA, 8'h00);
    send_item(REQ_DATA, 8'hFF);
    send_item(REQ_DATA, CHAR_DEL);
    send_item(REQ_DATA, CHAR_TAB);
    send_item(REQ_DATA, CHAR_CR);
    send_item(REQ_DATA, CHAR_LF);
    send_item(REQ_EOF, 8'hA5);
  endtask

  task automatic test_line_marks();
    cfg_t c;
    c = '{number_all_lines: 1'b1, number_nonblank_lines: 1'b0, squeeze_blank_lines: 1'b1,
          show_line_ends: 1'b1, show_tabs: 1'b1, show_nonprinting: 1'b0};
    set_options(c);
    send_item(REQ_DATA, 8'h41);
    send_item(REQ_DATA, CHAR_CR);
    send_item(REQ_DATA, CHAR_LF);
    // Blank lines: the third LF and beyond are squeezed out.
    send_item(REQ_DATA, CHAR_LF);
    send_item(REQ_DATA, CHAR_LF);
    send_item(REQ_DATA, CHAR_LF);
    send_item(REQ_DATA, CHAR_CR);
    send_item(REQ_DATA, CHAR_CR);
    send_item(REQ_DATA, CHAR_TAB);
    send_item(REQ_DATA, CHAR_CR);
    send_item(REQ_EOF, 8'h5A);
    // A carriage return held across a change of options comes out raw.
    send_item(REQ_DATA, CHAR_CR);
    c.show_line_ends = 1'b0;
    set_options(c);
    send_item(REQ_DATA, CHAR_LF);
  endtask

  task automatic test_caret_forms();
    set_options(cfg_t'('1));
    send_item(REQ_DATA, 8'h00);
    send_item(REQ_DATA, 8'h1F);
    send_item(REQ_DATA, CHAR_DEL);
    send_item(REQ_DATA, CHAR_CR);
    send_item(REQ_DATA, CHAR_LF);
    send_item(REQ_DATA, 8'hFF);
  endtask

  function automatic byte_t pick_text_byte();
    int r;
    r = $urandom_range(99);
    if (r < 42) return byte_t'($urandom_range(32, 126));
    if (r < 60) return CHAR_LF;
    if (r < 68) return CHAR_CR;
    if (r < 74) return CHAR_TAB;
    if (r < 81) return byte_t'($urandom_range(0, 31));
    if (r < 84) return CHAR_DEL;
    if (r < 92) return byte_t'($urandom_range(128, 255));
    return byte_t'($urandom_range(0, 255));
  endfunction

  // Random text in three segments, each under freshly drawn options.
  task automatic test_random_text(int n_items);
    int   sent;
    int   burst;
    cfg_t c;
    for (int seg = 0; seg < 3; seg++) begin
      c = cfg_t'($urandom_range(63));
      set_options(c);
      sent = 0;
      while (sent < n_items / 3) begin
        if ($urandom_range(99) < 4) begin
          send_item(REQ_EOF, byte_t'($urandom_range(0, 255)));
          sent++;
        end else if ($urandom_range(99) < 6) begin
          // A run of blank lines to exercise squeezing.
          burst = $urandom_range(3, 5);
          repeat (burst) send_item(REQ_DATA, CHAR_LF);
          sent += burst;
        end else begin
          send_item(REQ_DATA, pick_text_byte());
          sent++;
        end
      end
    end
  endtask

  // The receiver holds off while the sender keeps offering long numbered runs.
  task automatic test_long_receiver_hold();
    cfg_t c;
    c = '{number_all_lines: 1'b1, number_nonblank_lines: 1'b0, squeeze_blank_lines: 1'b0,
          show_line_ends: 1'b1, show_tabs: 1'b1, show_nonprinting: 1'b1};
    set_options(c);
    ->long_hold_ev;
    for (int i = 0; i < 20; i++) begin
      send_item(REQ_DATA, (i % 2 == 0) ? CHAR_LF : pick_text_byte());
    end
  endtask

  initial begin
    opt          = cfg_t'(0);
    last_emitted = CHAR_LF;
    line_num     = 1;
    blank_cnt    = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 15;
    recv_idle_pct = 72;
    test_plain_bytes();
    test_line_marks();
    test_caret_forms();
    test_random_text(96);

    send_idle_pct = 72;
    recv_idle_pct = 15;
    test_random_text(96);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_text(90);
    test_long_receiver_hold();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("text_stream_line_formatter_top: match");
    end else begin
      $display("text_stream_line_formatter_top: mismatch");
    end
    $finish;
  end

endmodule

/* text_stream_line_formatter_top.f */
rtl/tslf_pkg.sv
rtl/tslf_format.sv
rtl/tslf_run_buf.sv
rtl/text_stream_line_formatter_top.sv
tb/text_stream_line_formatter_top_tb.sv
